/* hw/rtl/mwm_pkg.sv */
// Shared types and constants for the masked windowed mean block.
// Used by the controller, datapath and top level; no dependencies.
`timescale 1ns / 1ps

package mwm_pkg;

  localparam int MAX_HALF_WIDTH_DEF = 32;
  localparam int DATA_W             = 32;
  localparam int CFG_W              = 6;
  localparam int SEEN_W             = 7;

  localparam logic [CFG_W-1:0]  HALF_WIDTH_RST = 6'd25;
  localparam logic [SEEN_W-1:0] SEEN_MAX       = 7'd127;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_DRAIN,
    ST_LOAD,
    ST_DIV,
    ST_EMIT
  } mwm_state_e;

  // commands from the controller to the datapath
  typedef struct packed {
    logic accept;
    logic sweep_step;
    logic div_start;
    logic div_step;
    logic emit;
    logic next_center;
  } mwm_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic emit_now;
    logic sweep_end;
    logic div_done;
    logic more;
    logic out_free;
  } mwm_stat_t;

endpackage

/* hw/rtl/masked_windowed_mean.sv */
// Top level of the masked windowed mean block.
// Depends on mwm_pkg, mwm_ctrl, mwm_dp (which holds the mwm_ram ring).
//
//  channel  direction  handshake                   payload
//  in       input      in_valid_i / in_stall_o     sample_value_i, sample_valid_i, last_sample_i
//  out      output     out_valid_o / out_stall_i   mean_value_o, mean_valid_o, last_result_o
//  cfg      input      cfg_valid_i / cfg_ready_o   half_width_i
//
// A sample that produces no result is only taken in the idle state. A sample that
// produces a result then passes the sweep, drain, load, divide and emit states, with
// the window length at most 2*half_width + 1: one ring read per window slot, then
// one quotient bit per cycle in the serial divider (39 steps by default) and a
// check that it is done. An output stall holds the block in the emit state.
// A last sample repeats the sweep and divide for every flushed result.
// Reset sets half_width to 25 and starts an empty sequence; the ring is not cleared.
// A stalled output holds the finished result while the next sample is taken.
`timescale 1ns / 1ps

module masked_windowed_mean import mwm_pkg::*; #(
  parameter int MAX_HALF_WIDTH = MAX_HALF_WIDTH_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic signed [DATA_W-1:0] sample_value_i,
  input  logic                     sample_valid_i,
  input  logic                     last_sample_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic signed [DATA_W-1:0] mean_value_o,
  output logic                     mean_valid_o,
  output logic                     last_result_o,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [CFG_W-1:0]         half_width_i
);

  mwm_cmd_t  cmd;
  mwm_stat_t stat;

  assign cfg_ready_o = 1'b1;

  mwm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  mwm_dp #(
    .MAX_HALF_WIDTH (MAX_HALF_WIDTH)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .cfg_we_i       (cfg_valid_i),
    .half_width_i   (half_width_i),
    .sample_value_i (sample_value_i),
    .sample_valid_i (sample_valid_i),
    .last_sample_i  (last_sample_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .mean_value_o   (mean_value_o),
    .mean_valid_o   (mean_valid_o),
    .last_result_o  (last_result_o)
  );

endmodule

/* hw/rtl/mwm_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module mwm_ram #(
  parameter int WIDTH = 33,
  parameter int DEPTH = 65
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* hw/rtl/mwm_ctrl.sv */
// Controller state machine for the masked windowed mean block.
// Depends on mwm_pkg; drives commands into mwm_dp and reads its status.
`timescale 1ns / 1ps

module mwm_ctrl import mwm_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  mwm_stat_t stat_i,
  output mwm_cmd_t  cmd_o
);

  mwm_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          if (stat_i.emit_now) begin
            state_d = ST_SWEEP;
          end
        end
      end
      ST_SWEEP: begin
        cmd_o.sweep_step = 1'b1;
        if (stat_i.sweep_end) begin
          state_d = ST_DRAIN;
        end
      end
      // last read word lands in the accumulator
      ST_DRAIN: begin
        state_d = ST_LOAD;
      end
      ST_LOAD: begin
        cmd_o.div_start = 1'b1;
        state_d         = ST_DIV;
      end
      ST_DIV: begin
        if (stat_i.div_done) begin
          state_d = ST_EMIT;
        end else begin
          cmd_o.div_step = 1'b1;
        end
      end
      ST_EMIT: begin
        if (stat_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (stat_i.more) begin
            cmd_o.next_center = 1'b1;
            state_d           = ST_SWEEP;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign in_stall_o = (state_q != ST_IDLE);

  a_emit_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT && stat_i.out_free && !stat_i.more) |=> state_q == ST_IDLE)
    else $error("controller did not return to idle after final result");

endmodule

/* hw/rtl/mwm_dp.sv */
// Datapath: sample ring, window sweep accumulator, serial divider, output register.
// Depends on mwm_pkg and mwm_ram; steered by mwm_ctrl.
`timescale 1ns / 1ps

module mwm_dp import mwm_pkg::*; #(
  parameter int MAX_HALF_WIDTH = MAX_HALF_WIDTH_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  mwm_cmd_t                 cmd_i,
  output mwm_stat_t                stat_o,
  input  logic                     cfg_we_i,
  input  logic [CFG_W-1:0]         half_width_i,
  input  logic signed [DATA_W-1:0] sample_value_i,
  input  logic                     sample_valid_i,
  input  logic                     last_sample_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic signed [DATA_W-1:0] mean_value_o,
  output logic                     mean_valid_o,
  output logic                     last_result_o
);

  localparam int DEPTH = 2 * MAX_HALF_WIDTH + 1;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);
  localparam int SW    = DATA_W + AW;
  localparam int DCW   = $clog2(SW + 1);
  localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);

  logic [CFG_W-1:0]  half_width_q;
  logic [AW-1:0]     ptr_q, newest_q, slot_q, k_q, d_q;
  logic [SEEN_W-1:0] seen_q, seen_win_q;
  logic              flush_q;
  logic              acc_en_q, ctr_q, cvalid_q;
  logic signed [SW-1:0] sum_q;
  logic [CW-1:0]     cnt_q;
  logic [SW-1:0]     quo_q;
  logic [CW-1:0]     rem_q;
  logic [DCW-1:0]    div_cnt_q;
  logic              sign_q;
  logic              out_valid_q, mean_valid_q, last_result_q;
  logic signed [DATA_W-1:0] mean_value_q;

  logic [AW-1:0]     h_eff, dh, kend;
  logic [SEEN_W-1:0] seen_new, seen_m1;
  logic              emit_now;
  logic [DATA_W:0]   rd_word;
  logic [DATA_W:0]   wr_word;
  logic [SW-1:0]     mag, dividend;
  logic [CW:0]       trial;
  logic              trial_ge;
  logic [DATA_W-1:0] q_lo, q_signed;

  // ring of {valid, value}
  assign wr_word = {sample_valid_i, sample_value_i};

  mwm_ram #(
    .WIDTH (DATA_W + 1),
    .DEPTH (DEPTH)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (cmd_i.accept),
    .waddr_i (ptr_q),
    .wdata_i (wr_word),
    .re_i    (cmd_i.sweep_step),
    .raddr_i (slot_q),
    .rdata_o (rd_word)
  );

  // clamp oversized half width
  assign h_eff = (half_width_q > CFG_W'(MAX_HALF_WIDTH)) ? AW'(MAX_HALF_WIDTH)
                                                        : AW'(half_width_q);

  assign seen_new = (seen_q == SEEN_MAX) ? seen_q : seen_q + 1'b1;
  assign emit_now = last_sample_i || (SEEN_W'(h_eff) < seen_new);

  // window runs from the newest sample back to min(d + h, seen - 1)
  assign dh      = d_q + h_eff;
  assign seen_m1 = seen_win_q - 1'b1;
  assign kend    = (SEEN_W'(dh) < seen_m1) ? dh : AW'(seen_m1);

  assign mag      = sum_q[SW-1] ? SW'(-sum_q) : SW'(sum_q);
  assign dividend = mag + SW'(cnt_q >> 1);
  assign trial    = {rem_q, quo_q[SW-1]};
  assign trial_ge = (trial >= {1'b0, cnt_q});
  assign q_lo     = quo_q[DATA_W-1:0];
  assign q_signed = sign_q ? (~q_lo + 1'b1) : q_lo;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_width_q <= HALF_WIDTH_RST;
      ptr_q        <= '0;
      seen_q       <= '0;
      acc_en_q     <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        half_width_q <= half_width_i;
      end
      if (cmd_i.accept) begin
        if (last_sample_i) begin
          ptr_q  <= '0;
          seen_q <= '0;
        end else begin
          ptr_q  <= (ptr_q == LAST_SLOT) ? '0 : ptr_q + 1'b1;
          seen_q <= seen_new;
        end
      end
      acc_en_q <= cmd_i.sweep_step;
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ctr_q <= (k_q == d_q);
    if (cmd_i.accept) begin
      newest_q   <= ptr_q;
      slot_q     <= ptr_q;
      k_q        <= '0;
      sum_q      <= '0;
      cnt_q      <= '0;
      seen_win_q <= seen_new;
      flush_q    <= last_sample_i;
      d_q        <= (SEEN_W'(h_eff) < seen_new) ? h_eff : AW'(seen_new - 1'b1);
    end else if (cmd_i.next_center) begin
      slot_q <= newest_q;
      k_q    <= '0;
      sum_q  <= '0;
      cnt_q  <= '0;
      d_q    <= d_q - 1'b1;
    end else begin
      if (cmd_i.sweep_step) begin
        slot_q <= (slot_q == '0) ? LAST_SLOT : slot_q - 1'b1;
        k_q    <= k_q + 1'b1;
      end
      if (acc_en_q) begin
        if (rd_word[DATA_W]) begin
          sum_q <= sum_q + SW'(signed'(rd_word[DATA_W-1:0]));
          cnt_q <= cnt_q + 1'b1;
        end
        if (ctr_q) begin
          cvalid_q <= rd_word[DATA_W];
        end
      end
    end
    // restoring divide, one quotient bit per step
    if (cmd_i.div_start) begin
      quo_q     <= dividend;
      rem_q     <= '0;
      div_cnt_q <= '0;
      sign_q    <= sum_q[SW-1];
    end else if (cmd_i.div_step) begin
      rem_q     <= trial_ge ? CW'(trial - {1'b0, cnt_q}) : trial[CW-1:0];
      quo_q     <= {quo_q[SW-2:0], trial_ge};
      div_cnt_q <= div_cnt_q + 1'b1;
    end
    if (cmd_i.emit) begin
      if (cvalid_q && cnt_q != '0) begin
        mean_value_q <= q_signed;
        mean_valid_q <= 1'b1;
      end else begin
        mean_value_q <= '0;
        mean_valid_q <= 1'b0;
      end
      last_result_q <= flush_q && (d_q == '0);
    end
  end

  assign stat_o.emit_now  = emit_now;
  assign stat_o.sweep_end = (k_q == kend);
  assign stat_o.div_done  = (div_cnt_q == DCW'(SW));
  assign stat_o.more      = flush_q && (d_q != '0);
  assign stat_o.out_free  = !out_valid_q || !out_stall_i;

  assign out_valid_o   = out_valid_q;
  assign mean_value_o  = mean_value_q;
  assign mean_valid_o  = mean_valid_q;
  assign last_result_o = last_result_q;

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> (!out_valid_q || !out_stall_i))
    else $error("result loaded over one still waiting");

  a_sweep_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.sweep_step |-> k_q <= kend)
    else $error("sweep ran past the window end");

  a_center_counted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.emit && cvalid_q) |-> cnt_q != '0)
    else $error("valid center but empty window count");

endmodule

/* verif/mwm_mean_checker.sv */
// Checker for the masked windowed mean block: watches the sample, result and
// config channels, predicts each windowed mean and compares the results.
// Depends on mwm_pkg for widths, the reset half width and the window limits.
`timescale 1ns / 1ps

module mwm_mean_checker import mwm_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_stall_i,
  input  logic [DATA_W-1:0] sample_value_i,
  input  logic              sample_valid_i,
  input  logic              last_sample_i,
  input  logic              out_valid_i,
  input  logic              out_stall_i,
  input  logic [DATA_W-1:0] mean_value_i,
  input  logic              mean_valid_i,
  input  logic              last_result_i,
  input  logic              cfg_valid_i,
  input  logic              cfg_ready_i,
  input  logic [CFG_W-1:0]  half_width_i,
  output int                failures_o,
  output int                open_results_o
);

  localparam int RING_DEPTH = 2 * MAX_HALF_WIDTH_DEF + 1;

  typedef struct packed {
    logic [DATA_W-1:0] value;
    logic              ok;
    logic              last;
  } mean_result_t;

  logic signed [DATA_W-1:0] ring_value [RING_DEPTH];
  logic                     ring_valid [RING_DEPTH];
  logic [CFG_W-1:0]         half_width_q;
  int unsigned              seen_count;
  int unsigned              write_slot;
  int unsigned              results_seen;
  mean_result_t             pending_means [$];

  // slot of the sample 'back' positions before the newest one
  function automatic int unsigned slot_back(int unsigned back);
    return (write_slot + 2 * RING_DEPTH - 1 - back) % RING_DEPTH;
  endfunction

  function automatic mean_result_t window_mean(int unsigned center, int unsigned h,
                                               logic is_last);
    int unsigned       k;
    int unsigned       kend;
    int unsigned       cnt;
    int unsigned       s;
    longint            sum;
    longint unsigned   mag;
    longint unsigned   quo;
    mean_result_t      r;
    k    = (center > h) ? center - h : 0;
    kend = center + h;
    sum  = 0;
    cnt  = 0;
    while (k <= kend && k < seen_count && k < RING_DEPTH) begin
      s = slot_back(k);
      if (ring_valid[s]) begin
        sum += ring_value[s];
        cnt++;
      end
      k++;
    end
    r.last = is_last;
    if (ring_valid[slot_back(center)] && cnt != 0) begin
      // round half away from zero on the magnitude
      mag = (sum < 0) ? -sum : sum;
      quo = (mag + cnt / 2) / cnt;
      if (sum < 0) quo = -quo;
      r.value = quo[DATA_W-1:0];
      r.ok    = 1'b1;
    end else begin
      r.value = '0;
      r.ok    = 1'b0;
    end
    return r;
  endfunction

  task automatic take_sample(logic [DATA_W-1:0] v, logic ok, logic is_last);
    int unsigned h;
    int          d;
    h = (half_width_q > MAX_HALF_WIDTH_DEF) ? MAX_HALF_WIDTH_DEF : half_width_q;
    ring_value[write_slot] = v;
    ring_valid[write_slot] = ok;
    write_slot = (write_slot == RING_DEPTH - 1) ? 0 : write_slot + 1;
    if (seen_count < SEEN_MAX) seen_count++;
    if (!is_last) begin
      if (h < seen_count) pending_means.push_back(window_mean(h, h, 1'b0));
    end else begin
      // flush every center still owed, oldest first
      d = (h < seen_count) ? h : seen_count - 1;
      for (int c = d; c >= 0; c--) begin
        pending_means.push_back(window_mean(c, h, c == 0));
      end
      seen_count = 0;
      write_slot = 0;
    end
  endtask

  task automatic report_mismatch(string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    failures_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    mean_result_t want;
    if (!rst_ni) begin
      half_width_q = HALF_WIDTH_RST;
      seen_count   = 0;
      write_slot   = 0;
      results_seen = 0;
      pending_means.delete();
      for (int i = 0; i < RING_DEPTH; i++) begin
        ring_value[i] = '0;
        ring_valid[i] = 1'b0;
      end
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (pending_means.size() == 0) begin
          report_mismatch($sformatf("result %0d arrived with no sample owing it",
                                    results_seen));
        end else begin
          want = pending_means.pop_front();
          if (mean_value_i !== want.value)
            report_mismatch($sformatf("result %0d mean_value expected %0h got %0h",
                                      results_seen, want.value, mean_value_i));
          if (mean_valid_i !== want.ok)
            report_mismatch($sformatf("result %0d mean_valid expected %0b got %0b",
                                      results_seen, want.ok, mean_valid_i));
          if (last_result_i !== want.last)
            report_mismatch($sformatf("result %0d last_result expected %0b got %0b",
                                      results_seen, want.last, last_result_i));
        end
        results_seen++;
      end
      if (cfg_valid_i && cfg_ready_i) half_width_q = half_width_i;
      if (in_valid_i && !in_stall_i) take_sample(sample_value_i, sample_valid_i, last_sample_i);
    end
    open_results_o = pending_means.size();
  end

endmodule

/* verif/masked_windowed_mean_tb.sv */
// Testbench top for the masked windowed mean block: drives sample sequences,
// half width writes and output stalls; the checker module does the compares.
// Depends on mwm_pkg, masked_windowed_mean and mwm_mean_checker.
`timescale 1ns / 1ps

module masked_windowed_mean_tb import mwm_pkg::*; ();

  localparam int DIRECTED_ITEMS = 24;
  localparam int RANDOM_ITEMS   = 446;
  localparam int QUIET_AFTER    = 400;
  localparam int LONG_SEQ       = 130;
  localparam int HW_TOP         = (1 << CFG_W) - 1;
  // one full window sweep plus the serial divide, doubled
  localparam int SETTLE_CYCLES  = 2 * (2 * MAX_HALF_WIDTH_DEF + 45);

  localparam logic [DATA_W-1:0] Q_MAX     = 32'h7FFF_FFFF;
  localparam logic [DATA_W-1:0] Q_MIN     = 32'h8000_0000;
  localparam logic [DATA_W-1:0] Q_NEG_ONE = 32'hFFFF_FFFF;

  typedef enum int {
    STYLE_FULL,
    STYLE_NEAR_ZERO,
    STYLE_EXTREME
  } value_style_e;

  logic              clk_i;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_stall_o;
  logic [DATA_W-1:0] sample_value_i;
  logic              sample_valid_i;
  logic              last_sample_i;
  logic              out_valid_o;
  logic              out_stall_i;
  logic [DATA_W-1:0] mean_value_o;
  logic              mean_valid_o;
  logic              last_result_o;
  logic              cfg_valid_i;
  logic              cfg_ready_o;
  logic [CFG_W-1:0]  half_width_i;

  int failures;
  int open_results;
  int items_sent;
  int idle_pct;
  bit quiet;

  masked_windowed_mean uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .sample_value_i (sample_value_i),
    .sample_valid_i (sample_valid_i),
    .last_sample_i  (last_sample_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .mean_value_o   (mean_value_o),
    .mean_valid_o   (mean_valid_o),
    .last_result_o  (last_result_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .half_width_i   (half_width_i)
  );

  mwm_mean_checker mean_check (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_i     (in_stall_o),
    .sample_value_i (sample_value_i),
    .sample_valid_i (sample_valid_i),
    .last_sample_i  (last_sample_i),
    .out_valid_i    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .mean_value_i   (mean_value_o),
    .mean_valid_i   (mean_valid_o),
    .last_result_i  (last_result_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_i    (cfg_ready_o),
    .half_width_i   (half_width_i),
    .failures_o     (failures),
    .open_results_o (open_results)
  );

  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  initial begin
    #400_000_000;
    $display("Verification failed");
    $finish;
  end

  // output stall bursts
  initial begin
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (!quiet && idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 16)) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  function automatic logic [DATA_W-1:0] pick_value(value_style_e style);
    case (style)
      STYLE_NEAR_ZERO: return DATA_W'($urandom_range(0, 200)) - DATA_W'(100);
      STYLE_EXTREME: begin
        case ($urandom_range(0, 5))
          0:       return Q_MAX;
          1:       return Q_MIN;
          2:       return '0;
          3:       return Q_NEG_ONE;
          4:       return Q_MAX - 1;
          default: return Q_MIN + 1;
        endcase
      end
      default: return $urandom;
    endcase
  endfunction

  // leaves the request up; the caller either sends again or drops it
  task automatic send_sample(logic [DATA_W-1:0] v, logic ok, logic is_last);
    if (!quiet && idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    sample_value_i <= v;
    sample_valid_i <= ok;
    last_sample_i  <= is_last;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    items_sent++;
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    wait (open_results == 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_half_width(logic [CFG_W-1:0] hw);
    cfg_valid_i  <= 1'b1;
    half_width_i <= hw;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic run_sequence(int unsigned len, int unsigned invalid_pct,
                              value_style_e style, int unsigned split_at);
    for (int unsigned i = 0; i < len; i++) begin
      if (i == split_at) begin
        // change the window in the middle of the sequence
        settle();
        write_half_width(CFG_W'($urandom_range(0, HW_TOP)));
      end
      send_sample(pick_value(style), $urandom_range(0, 99) >= invalid_pct, i == len - 1);
    end
  endtask

  initial begin
    int unsigned      r;
    int unsigned      h_eff;
    int unsigned      len;
    int unsigned      split_at;
    int unsigned      n_seq;
    int unsigned      invalid_pct;
    logic [CFG_W-1:0] hw_pick;
    bit               long_pending;

    quiet          = 1'b0;
    idle_pct       = 5;
    items_sent     = 0;
    rst_ni         <= 1'b0;
    in_valid_i     <= 1'b0;
    sample_value_i <= '0;
    sample_valid_i <= 1'b0;
    last_sample_i  <= 1'b0;
    cfg_valid_i    <= 1'b0;
    half_width_i   <= '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset half width, short sequence: extremes and an invalid center
    send_sample(Q_MAX, 1'b1, 1'b0);
    send_sample(Q_MIN, 1'b1, 1'b0);
    send_sample(32'h1234_5678, 1'b0, 1'b1);
    settle();

    // ties round away from zero, then a fully masked sequence
    write_half_width(CFG_W'(1));
    send_sample(DATA_W'(1), 1'b1, 1'b0);
    send_sample(DATA_W'(2), 1'b1, 1'b1);
    send_sample(Q_NEG_ONE, 1'b1, 1'b0);
    send_sample(Q_NEG_ONE - 1, 1'b1, 1'b1);
    send_sample(DATA_W'(5), 1'b0, 1'b0);
    send_sample(DATA_W'(7), 1'b0, 1'b1);
    settle();

    // zero width: each mean is its own sample; a one sample sequence
    write_half_width('0);
    send_sample(DATA_W'(-3), 1'b1, 1'b0);
    send_sample(Q_MAX, 1'b1, 1'b0);
    send_sample(Q_MIN, 1'b1, 1'b1);
    send_sample(32'hDEAD_BEEF, 1'b1, 1'b1);
    settle();

    // oversized width acts as the maximum
    write_half_width(CFG_W'(HW_TOP));
    repeat (3) send_sample(Q_MAX, 1'b1, 1'b0);
    send_sample(Q_MAX, 1'b1, 1'b1);
    settle();

    // width changed in the middle of a sequence
    write_half_width(CFG_W'(2));
    repeat (4) send_sample(pick_value(STYLE_NEAR_ZERO), 1'b1, 1'b0);
    settle();
    write_half_width(CFG_W'(4));
    send_sample(pick_value(STYLE_NEAR_ZERO), 1'b1, 1'b0);
    send_sample(pick_value(STYLE_NEAR_ZERO), 1'b0, 1'b0);
    send_sample(pick_value(STYLE_NEAR_ZERO), 1'b1, 1'b1);

    long_pending = 1'b1;
    while (items_sent < DIRECTED_ITEMS + RANDOM_ITEMS) begin
      settle();
      quiet = (items_sent >= DIRECTED_ITEMS + QUIET_AFTER);
      r = $urandom_range(0, 99);
      if (long_pending)  hw_pick = CFG_W'($urandom_range(0, 4));
      else if (r < 15)   hw_pick = '0;
      else if (r < 25)   hw_pick = CFG_W'(MAX_HALF_WIDTH_DEF);
      else if (r < 32)   hw_pick = CFG_W'($urandom_range(MAX_HALF_WIDTH_DEF + 1, HW_TOP));
      else if (r < 50)   hw_pick = CFG_W'($urandom_range(0, HW_TOP));
      else               hw_pick = CFG_W'($urandom_range(1, 8));
      write_half_width(hw_pick);
      h_eff = (hw_pick > MAX_HALF_WIDTH_DEF) ? MAX_HALF_WIDTH_DEF : hw_pick;
      case ($urandom_range(0, 2))
        0:       idle_pct = 0;
        1:       idle_pct = 4;
        default: idle_pct = 15;
      endcase
      if (quiet) idle_pct = 0;
      n_seq = $urandom_range(1, 3);
      for (int s = 0; s < n_seq; s++) begin
        r = $urandom_range(0, 99);
        if (long_pending) len = LONG_SEQ;
        else if (r < 20)  len = $urandom_range(1, h_eff + 1);
        else if (r < 92)  len = $urandom_range(h_eff + 1, h_eff + 24);
        else              len = $urandom_range(2 * MAX_HALF_WIDTH_DEF + 2, 80);
        long_pending = 1'b0;
        split_at = len;
        if (len >= 4 && $urandom_range(0, 9) == 0) split_at = $urandom_range(1, len - 1);
        r = $urandom_range(0, 99);
        if (r < 45)      invalid_pct = 0;
        else if (r < 85) invalid_pct = 25;
        else if (r < 95) invalid_pct = 60;
        else             invalid_pct = 100;
        run_sequence(len, invalid_pct, value_style_e'($urandom_range(0, 2)), split_at);
      end
    end

    settle();
    if (failures == 0 && open_results == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

/* filelist.f */
hw/rtl/mwm_pkg.sv
hw/rtl/mwm_ram.sv
hw/rtl/mwm_ctrl.sv
hw/rtl/mwm_dp.sv
hw/rtl/masked_windowed_mean.sv
verif/mwm_mean_checker.sv
verif/masked_windowed_mean_tb.sv
